>>> hw/rtl/wamf_pkg.sv
// wamf_pkg: shared types, widths and constants of the 3x3 mean / median filter
// no dependencies; imported by the channel interfaces and the top level
`default_nettype none

package wamf_pkg;

    // pixel and window geometry
    localparam int PIX_W       = 8;
    localparam int KERNEL_SIZE = 3;
    localparam int CELLS       = KERNEL_SIZE * KERNEL_SIZE;
    localparam int ROW_W       = 2 * PIX_W;

    // configuration register widths
    localparam int MODE_W     = 1;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 2;

    // compare width for geometry, holds any bound plus one
    localparam int GEOM_W = 13;

    // default line store depth
    localparam int MAX_WIDTH_DEF = 1024;

    // register reset values
    localparam logic [MODE_W-1:0]   MODE_RST   = 1'b0;
    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 12'd768;

    // mean: floor((sum + 4) / 9) as (sum + 4) * 7282 >> 16, exact for sum + 4 <= 2303
    localparam int ROW_SUM_W  = 10;
    localparam int SUM_W      = 12;
    localparam int RECIP_W    = 13;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int MEAN_SHIFT = 16;
    localparam logic [RECIP_W-1:0] MEAN_RECIP = 13'd7282;
    localparam logic [SUM_W-1:0]   MEAN_HALF  = 12'd4;

    // result queue
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
    localparam int IN_FLIGHT = 5;
    localparam int FLIGHT_W  = $clog2(IN_FLIGHT + 1);

    // register indexes of the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FILTER_MODE  = 2'd0,
        REG_IMAGE_WIDTH  = 2'd1,
        REG_IMAGE_HEIGHT = 2'd2
    } t_cfg_idx;

    // filter modes
    typedef enum logic [MODE_W-1:0] {
        MODE_MEAN   = 1'b0,
        MODE_MEDIAN = 1'b1
    } t_mode;

    // one queued result
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_out_item;

endpackage

`default_nettype wire

>>> hw/rtl/wamf_if.sv
// wamf_if: valid / ready channels for the pixel input and the filtered output
// depends on wamf_pkg for the pixel width
`default_nettype none

interface wamf_pix_in_if;
    import wamf_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

interface wamf_pix_out_if;
    import wamf_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_out;
    logic             frame_last;

    modport source (output valid, output pixel_out, output frame_last, input ready);
    modport sink   (input valid, input pixel_out, input frame_last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/wamf_ram.sv
// wamf_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module wamf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/window_average_median_filter.sv
// window_average_median_filter: 3x3 mean / median filter, valid / ready output
// depends on wamf_pkg, wamf_if (channels) and wamf_ram (line store)
//
//   channel  | dir | beat payload              | handshake
//   ---------+-----+---------------------------+-------------------------
//   i_pix    | in  | pixel_in[7:0]             | valid / ready
//   o_pix    | out | pixel_out[7:0], frame_last| valid / ready
//   i_cfg_*  | in  | index[1:0], data[11:0]    | write enable, no wait
//
// one pixel per clock while ready is high; a result is registered through the pipeline
// stages and then passes through an 8-entry output queue
// the line store is one ram read at acceptance and written back in the cycle after;
// consecutive pixels hit different columns, so no read can meet a pending write
// ready drops only when queued plus in-flight results would fill the queue
// synchronous active-low reset clears counters, window, pipeline and queue;
// the line store is not cleared and needs no clearing pass
`default_nettype none

module window_average_median_filter #(
    parameter int MAX_WIDTH = wamf_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [wamf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [wamf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    wamf_pix_in_if.sink                     i_pix,
    wamf_pix_out_if.source                  o_pix
);
    import wamf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    // ---------------------------------------------------------------- helpers
    function automatic logic [PIX_W-1:0] f_min(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [PIX_W-1:0] f_max(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
        return (a < b) ? b : a;
    endfunction

    function automatic logic [PIX_W-1:0] f_med3(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b,
                                                input logic [PIX_W-1:0] c);
        return f_max(f_min(a, b), f_min(f_max(a, b), c));
    endfunction

    // ---------------------------------------------------------------- config
    logic [MODE_W-1:0]   r_mode;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_RST;
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FILTER_MODE:  r_mode   <= i_cfg_data[MODE_W-1:0];
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data[HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped geometry
    logic [GEOM_W-1:0] w_width_ext;
    logic [GEOM_W-1:0] w_height_ext;
    logic [GEOM_W-1:0] w_used_w;
    logic [GEOM_W-1:0] w_used_h;

    always_comb begin
        w_width_ext  = GEOM_W'(r_width);
        w_height_ext = GEOM_W'(r_height);
        if (w_width_ext < GEOM_W'(KERNEL_SIZE)) begin
            w_used_w = GEOM_W'(KERNEL_SIZE);
        end else if (w_width_ext > GEOM_W'(MAX_WIDTH)) begin
            w_used_w = GEOM_W'(MAX_WIDTH);
        end else begin
            w_used_w = w_width_ext;
        end
        w_used_h = (w_height_ext < GEOM_W'(KERNEL_SIZE)) ? GEOM_W'(KERNEL_SIZE)
                                                         : w_height_ext;
    end

    // ---------------------------------------------------------------- accept
    logic                r_ready;
    logic                w_in_fire;
    logic [CW-1:0]       r_col;
    logic [CW-1:0]       n_col;
    logic [HEIGHT_W-1:0] r_row;
    logic [HEIGHT_W-1:0] n_row;
    logic                w_end_row;
    logic                w_end_frame;
    logic                w_has_res;

    assign i_pix.ready = r_ready;
    assign w_in_fire   = i_pix.valid && r_ready;

    always_comb begin
        w_end_row   = (GEOM_W'(r_col) + GEOM_W'(1)) >= w_used_w;
        w_end_frame = w_end_row && ((GEOM_W'(r_row) + GEOM_W'(1)) >= w_used_h);
        w_has_res   = (GEOM_W'(r_col) >= GEOM_W'(KERNEL_SIZE - 1))
                   && (GEOM_W'(r_row) >= GEOM_W'(KERNEL_SIZE - 1));
        n_col = r_col;
        n_row = r_row;
        if (w_in_fire) begin
            if (w_end_row) begin
                n_col = '0;
                n_row = w_end_frame ? '0 : r_row + HEIGHT_W'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // stage 1: line store read in flight
    logic             r_p1_act;
    logic             r_p1_res;
    logic             r_p1_last;
    logic [PIX_W-1:0] r_p1_px;
    logic [CW-1:0]    r_p1_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_act <= 1'b0;
            r_p1_res <= 1'b0;
        end else begin
            r_p1_act <= w_in_fire;
            r_p1_res <= w_in_fire && w_has_res;
        end
        r_p1_last <= w_end_frame;
        r_p1_px   <= i_pix.pixel_in;
        r_p1_col  <= r_col;
    end

    // ---------------------------------------------------------------- line store
    logic [ROW_W-1:0] w_above;
    logic [ROW_W-1:0] w_store_wdata;

    assign w_store_wdata = {w_above[PIX_W-1:0], r_p1_px};

    wamf_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (r_p1_act),
        .i_waddr (r_p1_col),
        .i_wdata (w_store_wdata),
        .i_raddr (r_col),
        .o_rdata (w_above)
    );

    // ---------------------------------------------------------------- window
    logic [PIX_W-1:0] r_win [CELLS];
    logic             r_p2_res;
    logic             r_p2_last;

    // shift columns left, new column from line store and the incoming pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                r_win[i] <= '0;
            end
        end else if (r_p1_act) begin
            for (int y = 0; y < KERNEL_SIZE; y++) begin
                for (int x = 0; x < KERNEL_SIZE - 1; x++) begin
                    r_win[y*KERNEL_SIZE + x] <= r_win[y*KERNEL_SIZE + x + 1];
                end
            end
            r_win[KERNEL_SIZE - 1]               <= w_above[ROW_W-1:PIX_W];
            r_win[2*KERNEL_SIZE - 1]             <= w_above[PIX_W-1:0];
            r_win[KERNEL_SIZE*KERNEL_SIZE - 1]   <= r_p1_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_res <= 1'b0;
        end else begin
            r_p2_res <= r_p1_res;
        end
        r_p2_last <= r_p1_last;
    end

    // ---------------------------------------------------------------- stage 3
    // per-row sort of three and per-row sum
    logic [PIX_W-1:0]     r_p3_lo  [KERNEL_SIZE];
    logic [PIX_W-1:0]     r_p3_mid [KERNEL_SIZE];
    logic [PIX_W-1:0]     r_p3_hi  [KERNEL_SIZE];
    logic [ROW_SUM_W-1:0] r_p3_sum [KERNEL_SIZE];
    logic                 r_p3_res;
    logic                 r_p3_last;

    always_ff @(posedge i_clk) begin
        for (int y = 0; y < KERNEL_SIZE; y++) begin
            r_p3_lo[y]  <= f_min(f_min(r_win[y*KERNEL_SIZE], r_win[y*KERNEL_SIZE + 1]),
                                 r_win[y*KERNEL_SIZE + 2]);
            r_p3_mid[y] <= f_med3(r_win[y*KERNEL_SIZE], r_win[y*KERNEL_SIZE + 1],
                                  r_win[y*KERNEL_SIZE + 2]);
            r_p3_hi[y]  <= f_max(f_max(r_win[y*KERNEL_SIZE], r_win[y*KERNEL_SIZE + 1]),
                                 r_win[y*KERNEL_SIZE + 2]);
            r_p3_sum[y] <= ROW_SUM_W'(r_win[y*KERNEL_SIZE])
                         + ROW_SUM_W'(r_win[y*KERNEL_SIZE + 1])
                         + ROW_SUM_W'(r_win[y*KERNEL_SIZE + 2]);
        end
        r_p3_last <= r_p2_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p3_res <= 1'b0;
        end else begin
            r_p3_res <= r_p2_res;
        end
    end

    // ---------------------------------------------------------------- stage 4
    // max of row minima, median of row medians, min of row maxima; rounded total
    logic [PIX_W-1:0] r_p4_a;
    logic [PIX_W-1:0] r_p4_b;
    logic [PIX_W-1:0] r_p4_c;
    logic [SUM_W-1:0] r_p4_total;
    logic             r_p4_res;
    logic             r_p4_last;

    always_ff @(posedge i_clk) begin
        r_p4_a     <= f_max(f_max(r_p3_lo[0], r_p3_lo[1]), r_p3_lo[2]);
        r_p4_b     <= f_med3(r_p3_mid[0], r_p3_mid[1], r_p3_mid[2]);
        r_p4_c     <= f_min(f_min(r_p3_hi[0], r_p3_hi[1]), r_p3_hi[2]);
        r_p4_total <= SUM_W'(r_p3_sum[0]) + SUM_W'(r_p3_sum[1]) + SUM_W'(r_p3_sum[2])
                    + MEAN_HALF;
        r_p4_last  <= r_p3_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p4_res <= 1'b0;
        end else begin
            r_p4_res <= r_p3_res;
        end
    end

    // ---------------------------------------------------------------- stage 5
    // final median and reciprocal product for the divide by nine
    logic [PIX_W-1:0]  r_p5_med;
    logic [PROD_W-1:0] r_p5_prod;
    logic              r_p5_res;
    logic              r_p5_last;

    always_ff @(posedge i_clk) begin
        r_p5_med  <= f_med3(r_p4_a, r_p4_b, r_p4_c);
        r_p5_prod <= PROD_W'(r_p4_total) * PROD_W'(MEAN_RECIP);
        r_p5_last <= r_p4_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p5_res <= 1'b0;
        end else begin
            r_p5_res <= r_p4_res;
        end
    end

    // ---------------------------------------------------------------- output queue
    t_out_item            r_q_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_q_cnt;
    t_out_item            w_q_wdata;
    logic                 w_q_wr;
    logic                 w_q_rd;

    assign w_q_wr = r_p5_res;
    assign w_q_rd = o_pix.valid && o_pix.ready;

    always_comb begin
        w_q_wdata.last  = r_p5_last;
        w_q_wdata.pixel = (t_mode'(r_mode) == MODE_MEDIAN)
                        ? r_p5_med : r_p5_prod[MEAN_SHIFT +: PIX_W];
    end

    always_ff @(posedge i_clk) begin
        if (w_q_wr) begin
            r_q_mem[r_wr_ptr] <= w_q_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_q_cnt  <= '0;
        end else begin
            if (w_q_wr) begin
                r_wr_ptr <= (r_wr_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                                                                    : r_wr_ptr + OUT_PTR_W'(1);
            end
            if (w_q_rd) begin
                r_rd_ptr <= (r_rd_ptr == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0
                                                                    : r_rd_ptr + OUT_PTR_W'(1);
            end
            case ({w_q_wr, w_q_rd})
                2'b10:   r_q_cnt <= r_q_cnt + OUT_CNT_W'(1);
                2'b01:   r_q_cnt <= r_q_cnt - OUT_CNT_W'(1);
                default: r_q_cnt <= r_q_cnt;
            endcase
        end
    end

    assign o_pix.valid      = (r_q_cnt != '0);
    assign o_pix.pixel_out  = r_q_mem[r_rd_ptr].pixel;
    assign o_pix.frame_last = r_q_mem[r_rd_ptr].last;

    // ---------------------------------------------------------------- credit
    // accept only while every result in flight still has a queue slot
    logic [FLIGHT_W-1:0]    w_flight;
    logic [OUT_CNT_W:0]     w_credit;
    logic [OUT_CNT_W:0]     n_credit;

    always_comb begin
        w_flight = FLIGHT_W'(r_p1_res) + FLIGHT_W'(r_p2_res) + FLIGHT_W'(r_p3_res)
                 + FLIGHT_W'(r_p4_res) + FLIGHT_W'(r_p5_res);
        w_credit = (OUT_CNT_W + 1)'(r_q_cnt) + (OUT_CNT_W + 1)'(w_flight);
        // next-cycle occupancy: a new entry may enter stage 1, a beat may leave
        n_credit = w_credit
                 + (OUT_CNT_W + 1)'(w_in_fire && w_has_res)
                 - (OUT_CNT_W + 1)'(w_q_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ready <= 1'b0;
        end else begin
            r_ready <= n_credit < (OUT_CNT_W + 1)'(OUT_DEPTH - 1);
        end
    end

    // ---------------------------------------------------------------- checks
    // the queue never takes a result it has no room for
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_wr && !w_q_rd) |-> (r_q_cnt < OUT_CNT_W'(OUT_DEPTH)))
        else $error("output queue overflow");

    // queued plus in-flight results never exceed the queue
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_credit <= (OUT_CNT_W + 1)'(OUT_DEPTH))
        else $error("result credit exceeded");

    // column counter stays inside the line store
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        GEOM_W'(r_col) < GEOM_W'(MAX_WIDTH))
        else $error("column counter beyond line store");

    // a pixel that completes a window yields a queue write once it leaves the last pipeline stage
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && w_has_res) |-> ##5 w_q_wr)
        else $error("result lost in pipeline");

    // consecutive line store accesses never hit the same column
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && r_p1_act) |-> (r_col != r_p1_col))
        else $error("line store read meets pending write");

endmodule

`default_nettype wire
